// File: rtl/tbd_pkg.sv
package tbd_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_KERNEL = 16;
    localparam int RING       = MAX_KERNEL + 1;
    localparam int XW         = $clog2(MAX_WIDTH);
    localparam int SLW        = $clog2(RING);
    localparam int QDEPTH     = 8;
    localparam int QPW        = $clog2(QDEPTH);
    localparam int QCW        = $clog2(QDEPTH + 1);
    localparam int PIX_W      = 16;
    localparam int VW         = 23;
    localparam int SW         = 30;
    localparam int OUT_W      = 24;
    localparam int POS_W      = 10;
    localparam int DIM_W      = 11;

    typedef enum logic [2:0] {
        CFG_KERNEL = 3'd0,
        CFG_DOWN   = 3'd1,
        CFG_SCALE  = 3'd2,
        CFG_OFFSET = 3'd3,
        CFG_WIDTH  = 3'd4,
        CFG_HEIGHT = 3'd5
    } t_cfg_idx;

    typedef logic [3:0] t_wvec [MAX_KERNEL];

    typedef struct packed {
        logic [2:0]       rad;
        logic [4:0]       ds;
        logic [3:0]       off;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
    } t_geom;

    typedef struct packed {
        logic [XW-1:0]    p;
        logic             row_end;
        logic [POS_W-1:0] orow;
        logic             row_eof;
    } t_rowinfo;

    typedef struct packed {
        logic signed [VW-1:0] v;
        t_rowinfo             info;
    } t_qent;

    function automatic t_wvec kernel_weights(input logic [2:0] r, input logic even);
        t_wvec wv;
        int    dr;
        int    a;
        int    b;
        int    wt;
        for (int t = 0; t < MAX_KERNEL; t++) begin
            dr = t - int'(r) - 1;
            a  = (dr < 0) ? -dr : dr;
            wt = (a <= int'(r)) ? (int'(r) + 1 - a) : 0;
            if (even) begin
                b  = (dr + 1 < 0) ? -(dr + 1) : (dr + 1);
                wt = wt + ((b <= int'(r)) ? (int'(r) + 1 - b) : 0);
            end
            wv[t] = 4'(wt);
        end
        return wv;
    endfunction

endpackage

// File: rtl/tbd_fifo.sv
module tbd_fifo
    import tbd_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  t_qent          i_ent,
    input  logic           i_pop,
    output logic           o_valid,
    output t_qent          o_ent,
    output logic [QCW-1:0] o_count
);

    t_qent          r_mem [QDEPTH];
    logic [QPW-1:0] r_wp;
    logic [QPW-1:0] r_rp;
    logic [QCW-1:0] r_count;
    logic           w_pop;

    assign o_valid = (r_count != '0);
    assign o_ent   = r_mem[r_rp];
    assign o_count = r_count;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_ent;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == QPW'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == QPW'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_count <= r_count + QCW'(i_push) - QCW'(w_pop);
        end
    end

endmodule

// File: rtl/tbd_front.sv
module tbd_front
    import tbd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_geom             i_geom,
    input  t_wvec             i_wv,
    input  logic              i_restart,
    input  logic              i_valid,
    input  logic              i_cmd,
    input  logic [PIX_W-1:0]  i_pix,
    output logic              o_ready,
    input  logic [QCW-1:0]    i_q_count,
    output logic              o_push,
    output t_qent             o_ent
);

    logic [PIX_W-1:0] mem [RING][MAX_WIDTH];

    logic [DIM_W-1:0] r_y;
    logic [XW-1:0]    r_x;
    logic [SLW-1:0]   r_slot;
    logic [4:0]       r_iph;
    logic [POS_W-1:0] r_orow;

    logic [PIX_W-1:0] r1_rd [RING];
    logic             r1_valid;
    logic             r1_push;
    logic [PIX_W-1:0] r1_pix;
    logic [SLW-1:0]   r1_slot [MAX_KERNEL];
    logic             r1_byp [MAX_KERNEL];
    t_rowinfo         r1_info;

    logic signed [20:0] r2_prod [MAX_KERNEL];
    logic               r2_valid;
    logic               r2_push;
    t_rowinfo           r2_info;

    logic signed [VW-1:0] r3_part [4];
    logic                 r3_valid;
    logic                 r3_push;
    t_rowinfo             r3_info;

    logic                 w_accept;
    logic                 w_proc;
    logic                 w_wr;
    logic                 w_pix_row;
    logic signed [12:0]   w_i;
    logic signed [12:0]   w_y;
    logic signed [12:0]   w_off;
    logic signed [12:0]   w_ds;
    logic signed [12:0]   w_h;
    logic                 w_at_off;
    logic [4:0]           w_ph_eff;
    logic [POS_W-1:0]     w_orow_eff;
    logic                 w_irel;
    logic                 w_reof;
    logic                 w_last_col;
    logic                 w_frame_done;
    logic [4:0]           w_ph_inc;
    logic [SLW-1:0]       w_slot [MAX_KERNEL];
    logic                 w_byp [MAX_KERNEL];
    logic [QCW:0]         w_load;

    assign w_load  = {1'b0, i_q_count} + (QCW+1)'(r1_valid) + (QCW+1)'(r2_valid)
                   + (QCW+1)'(r3_valid);
    assign o_ready = (w_load < (QCW+1)'(QDEPTH));

    assign w_accept  = i_valid && o_ready;
    assign w_pix_row = (r_y < i_geom.h);
    assign w_proc    = w_accept && !(w_pix_row && i_cmd);
    assign w_wr      = w_proc && w_pix_row;

    assign w_y   = $signed({2'b0, r_y});
    assign w_i   = w_y - $signed({10'b0, i_geom.rad});
    assign w_off = $signed({9'b0, i_geom.off});
    assign w_ds  = $signed({8'b0, i_geom.ds});
    assign w_h   = $signed({2'b0, i_geom.h});

    assign w_at_off   = (w_i == w_off);
    assign w_ph_eff   = w_at_off ? '0 : r_iph;
    assign w_orow_eff = w_at_off ? '0 : r_orow;
    assign w_irel     = (w_at_off || ((w_i > w_off) && (r_iph == '0)))
                      && (w_i + w_ds - w_off <= w_h);
    assign w_reof     = w_irel && (w_i + w_ds + w_ds - w_off > w_h);
    assign w_ph_inc   = w_ph_eff + 5'd1;

    assign w_last_col   = ({1'b0, r_x} == i_geom.w - 1'b1);
    assign w_frame_done = w_last_col
                        && ({1'b0, r_y} == {1'b0, i_geom.h} + 12'(i_geom.rad) - 12'd1);

    always_comb begin
        logic signed [12:0] m;
        logic signed [12:0] mc;
        logic signed [12:0] d;
        logic [4:0]         dc;
        logic signed [6:0]  sl;
        for (int t = 0; t < MAX_KERNEL; t++) begin
            m  = w_i + 13'(t) - $signed({10'b0, i_geom.rad}) - 13'sd1;
            mc = (m < 0) ? 13'sd0 : ((m > w_h - 13'sd1) ? w_h - 13'sd1 : m);
            d  = w_y - mc;
            dc = ((d < 0) || (d > 13'(RING - 1))) ? 5'd0 : d[4:0];
            sl = $signed({2'b0, r_slot}) - $signed({2'b0, dc});
            if (sl < 0) begin
                sl = sl + 7'(RING);
            end
            w_slot[t] = sl[SLW-1:0];
            w_byp[t]  = (dc == 5'd0) && w_pix_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            for (int s = 0; s < RING; s++) begin
                r1_rd[s] <= mem[s][r_x];
                if (w_wr && (r_slot == SLW'(s))) begin
                    mem[s][r_x] <= i_pix;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_y      <= '0;
            r_x      <= '0;
            r_slot   <= '0;
            r_iph    <= '0;
            r_orow   <= '0;
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            r1_valid <= w_proc;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            if (i_restart) begin
                r_y    <= '0;
                r_x    <= '0;
                r_slot <= '0;
            end else if (w_proc) begin
                if (w_last_col) begin
                    r_x <= '0;
                    if (w_frame_done) begin
                        r_y    <= '0;
                        r_slot <= '0;
                    end else begin
                        r_y    <= r_y + 1'b1;
                        r_slot <= (r_slot == SLW'(RING - 1)) ? '0 : r_slot + 1'b1;
                        r_iph  <= (w_ph_inc == i_geom.ds) ? '0 : w_ph_inc;
                        r_orow <= w_orow_eff + POS_W'(w_ph_inc == i_geom.ds);
                    end
                end else begin
                    r_x <= r_x + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r1_push         <= w_irel;
        r1_pix          <= i_pix;
        r1_info.p       <= r_x;
        r1_info.row_end <= w_last_col;
        r1_info.orow    <= w_orow_eff;
        r1_info.row_eof <= w_reof;
        for (int t = 0; t < MAX_KERNEL; t++) begin
            r1_slot[t] <= w_slot[t];
            r1_byp[t]  <= w_byp[t];
        end

        r2_push <= r1_push;
        r2_info <= r1_info;
        for (int t = 0; t < MAX_KERNEL; t++) begin
            r2_prod[t] <= $signed(r1_byp[t] ? r1_pix : r1_rd[r1_slot[t]])
                        * $signed({1'b0, i_wv[t]});
        end

        r3_push <= r2_push;
        r3_info <= r2_info;
        for (int g = 0; g < 4; g++) begin
            r3_part[g] <= VW'(r2_prod[4*g]) + VW'(r2_prod[4*g+1])
                        + VW'(r2_prod[4*g+2]) + VW'(r2_prod[4*g+3]);
        end
    end

    assign o_push     = r3_valid && r3_push;
    assign o_ent.v    = r3_part[0] + r3_part[1] + r3_part[2] + r3_part[3];
    assign o_ent.info = r3_info;

endmodule

// File: rtl/tbd_back.sv
module tbd_back
    import tbd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_geom                i_geom,
    input  t_wvec                i_wv,
    input  logic [31:0]          i_scale,
    input  logic [OUT_W-1:0]     i_offset,
    input  logic                 i_head_valid,
    input  t_qent                i_head,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [OUT_W-1:0]     o_value,
    output logic [POS_W-1:0]     o_row,
    output logic [POS_W-1:0]     o_col,
    output logic                 o_last,
    output logic                 o_eof
);

    typedef struct packed {
        logic [POS_W-1:0] orow;
        logic [POS_W-1:0] ocol;
        logic             last;
        logic             eof;
    } t_tag;

    logic                 r_cur_valid;
    t_rowinfo             r_cur;
    logic [2:0]           r_e;
    logic signed [VW-1:0] r_win [MAX_KERNEL];
    logic signed [VW-1:0] r_v0;
    logic [4:0]           r_jph;
    logic [POS_W-1:0]     r_ocol;

    logic                 r1_valid;
    t_tag                 r1_tag;
    logic signed [27:0]   r1_prod [MAX_KERNEL];
    logic                 r2_valid;
    t_tag                 r2_tag;
    logic signed [SW-1:0] r2_part [4];
    logic                 r3_valid;
    t_tag                 r3_tag;
    logic signed [SW-1:0] r3_sum;
    logic                 r4_valid;
    t_tag                 r4_tag;
    logic signed [62:0]   r4_prod;
    logic                 r5_valid;
    t_tag                 r5_tag;
    logic [OUT_W-1:0]     r5_value;

    logic                 w_en;
    logic                 w_done;
    logic                 w_load;
    logic signed [12:0]   w_j;
    logic signed [12:0]   w_off;
    logic signed [12:0]   w_ds;
    logic signed [12:0]   w_w;
    logic                 w_at_off;
    logic [4:0]           w_ph_eff;
    logic [POS_W-1:0]     w_ocol_eff;
    logic [4:0]           w_ph_inc;
    logic                 w_jrel;
    logic                 w_more;
    logic signed [VW-1:0] w_op [MAX_KERNEL];
    logic signed [63:0]   w_round;
    logic signed [31:0]   w_q;

    assign w_en   = !r5_valid || i_ready;
    assign w_done = !r_cur_valid || (r_e == (r_cur.row_end ? i_geom.rad : 3'd0));
    assign w_load = w_en && w_done && i_head_valid;
    assign o_pop  = w_load;

    assign w_off = $signed({9'b0, i_geom.off});
    assign w_ds  = $signed({8'b0, i_geom.ds});
    assign w_w   = $signed({2'b0, i_geom.w});
    assign w_j   = $signed({3'b0, r_cur.p}) - $signed({10'b0, i_geom.rad})
                 + $signed({10'b0, r_e});

    assign w_at_off   = (w_j == w_off);
    assign w_ph_eff   = w_at_off ? '0 : r_jph;
    assign w_ocol_eff = w_at_off ? '0 : r_ocol;
    assign w_ph_inc   = w_ph_eff + 5'd1;
    assign w_more     = (w_j + w_ds + w_ds - w_off <= w_w);
    assign w_jrel     = (w_at_off || ((w_j > w_off) && (r_jph == '0)))
                      && (w_j + w_ds - w_off <= w_w);

    always_comb begin
        logic signed [6:0] d;
        logic [3:0]        dz;
        for (int t = 0; t < MAX_KERNEL; t++) begin
            d  = $signed({3'b0, i_geom.rad, 1'b1}) - $signed({4'b0, r_e}) - 7'(t);
            dz = (d < 0) ? 4'd0 : d[3:0];
            w_op[t] = ({6'b0, dz} > r_cur.p) ? r_v0 : r_win[dz];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_valid <= 1'b0;
            r_e         <= '0;
            r_jph       <= '0;
            r_ocol      <= '0;
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r4_valid    <= 1'b0;
            r5_valid    <= 1'b0;
        end else if (w_en) begin
            r1_valid <= r_cur_valid && w_jrel;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
            if (r_cur_valid && (w_j >= w_off)) begin
                r_jph  <= (w_ph_inc == i_geom.ds) ? '0 : w_ph_inc;
                r_ocol <= w_ocol_eff + POS_W'(w_ph_inc == i_geom.ds);
            end
            if (w_done) begin
                r_cur_valid <= i_head_valid;
                r_e         <= '0;
            end else begin
                r_e <= r_e + 1'b1;
            end
        end
    end

    assign w_round = 64'(r4_prod) + 64'sd2147483648;
    assign w_q     = 32'(w_round[63:32]) + 32'($signed(i_offset));

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_cur    <= i_head.info;
            r_win[0] <= i_head.v;
            for (int k = 1; k < MAX_KERNEL; k++) begin
                r_win[k] <= r_win[k-1];
            end
            if (i_head.info.p == '0) begin
                r_v0 <= i_head.v;
            end
        end
        if (w_en) begin
            r1_tag.orow <= r_cur.orow;
            r1_tag.ocol <= w_ocol_eff;
            r1_tag.last <= !(r_cur.row_end && w_more);
            r1_tag.eof  <= r_cur.row_eof && !w_more;
            for (int t = 0; t < MAX_KERNEL; t++) begin
                r1_prod[t] <= w_op[t] * $signed({1'b0, i_wv[t]});
            end
            r2_tag <= r1_tag;
            for (int g = 0; g < 4; g++) begin
                r2_part[g] <= SW'(r1_prod[4*g]) + SW'(r1_prod[4*g+1])
                            + SW'(r1_prod[4*g+2]) + SW'(r1_prod[4*g+3]);
            end
            r3_tag <= r2_tag;
            r3_sum <= r2_part[0] + r2_part[1] + r2_part[2] + r2_part[3];
            r4_tag  <= r3_tag;
            r4_prod <= r3_sum * $signed({1'b0, i_scale});
            r5_tag <= r4_tag;
            if (w_q > 32'sd8388607) begin
                r5_value <= 24'h7FFFFF;
            end else if (w_q < -32'sd8388608) begin
                r5_value <= 24'h800000;
            end else begin
                r5_value <= w_q[OUT_W-1:0];
            end
        end
    end

    assign o_valid = r5_valid;
    assign o_value = r5_value;
    assign o_row   = r5_tag.orow;
    assign o_col   = r5_tag.ocol;
    assign o_last  = r5_tag.last;
    assign o_eof   = r5_tag.eof;

endmodule

// File: rtl/triangular_blur_downscaler.sv
// Separable triangular blur with replicated borders and decimation by the
// configured factor in both directions.
// The slave stream takes one beat per pixel in raster order; tuser set marks
// a drain beat, and after the last pixel row one drain beat per pixel of each
// of the kernel radius rows flushes the bottom of the frame.
// The master stream carries one beat per output pixel; tlast closes the
// beats caused by one input beat and tuser marks the last beat of the frame.
// The configuration channel is always ready; it is to be written only while
// idle, which the block does not enforce; a geometry write restarts the frame.
// Within a row the input takes one beat per cycle while tready is high. The
// last pixel of a row also makes the horizontal stage finish the remaining
// output columns of that row, a backlog that the eight-entry queue soaks up;
// tready drops once the queue and the vertical stages hold eight entries.
// An input beat passes the registered line store, vertical adder tree and
// queue write, then the window load, horizontal tree, gain multiplier and
// rounding stage on its way to its first result.
// Reset restores the default registers and empties both stages; the line
// store is not cleared. When the master side stalls, the output stage holds
// its beat, the queue fills and the slave side drops tready.
module triangular_blur_downscaler
    import tbd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // pixel[15:0]
    input  logic        i_s_tuser,   // command[0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,   // filtered_value[23:0], out_row[33:24], out_col[43:34]
    output logic        o_m_tlast,
    output logic        o_m_tuser,   // end_of_frame[0]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic [4:0]       r_kernel;
    logic [4:0]       r_down;
    logic [31:0]      r_scale;
    logic [OUT_W-1:0] r_offset;
    logic [DIM_W-1:0] r_width;
    logic [DIM_W-1:0] r_height;

    t_geom            w_geom;
    t_wvec            w_wv;
    logic [4:0]       w_k;
    logic             w_restart;
    logic             w_push;
    t_qent            w_push_ent;
    logic             w_head_valid;
    t_qent            w_head;
    logic             w_pop;
    logic [QCW-1:0]   w_q_count;
    logic [OUT_W-1:0] w_value;
    logic [POS_W-1:0] w_row;
    logic [POS_W-1:0] w_col;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        w_restart = 1'b0;
        if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_KERNEL, CFG_DOWN, CFG_WIDTH, CFG_HEIGHT: w_restart = 1'b1;
                default: w_restart = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel <= 5'd3;
            r_down   <= 5'd1;
            r_scale  <= 32'd268435456;
            r_offset <= '0;
            r_width  <= 11'd1024;
            r_height <= 11'd1024;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_KERNEL: r_kernel <= i_cfg_data[4:0];
                CFG_DOWN:   r_down   <= i_cfg_data[4:0];
                CFG_SCALE:  r_scale  <= i_cfg_data;
                CFG_OFFSET: r_offset <= i_cfg_data[OUT_W-1:0];
                CFG_WIDTH:  r_width  <= i_cfg_data[DIM_W-1:0];
                CFG_HEIGHT: r_height <= i_cfg_data[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_k = (r_kernel == '0) ? 5'd1
            : ((r_kernel > 5'(MAX_KERNEL)) ? 5'(MAX_KERNEL) : r_kernel);
        w_geom.rad = 3'((w_k - 5'd1) >> 1);
        w_geom.ds  = (r_down == '0) ? 5'd1 : r_down;
        w_geom.off = w_geom.ds[4:1];
        w_geom.w   = (r_width == '0) ? 11'd1
                   : ((r_width > 11'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : r_width);
        w_geom.h   = (r_height == '0) ? 11'd1
                   : ((r_height > 11'd1024) ? 11'd1024 : r_height);
    end

    assign w_wv = kernel_weights(w_geom.rad, ~w_k[0]);

    tbd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_geom    (w_geom),
        .i_wv      (w_wv),
        .i_restart (w_restart),
        .i_valid   (i_s_tvalid),
        .i_cmd     (i_s_tuser),
        .i_pix     (i_s_tdata),
        .o_ready   (o_s_tready),
        .i_q_count (w_q_count),
        .o_push    (w_push),
        .o_ent     (w_push_ent)
    );

    tbd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_ent   (w_push_ent),
        .i_pop   (w_pop),
        .o_valid (w_head_valid),
        .o_ent   (w_head),
        .o_count (w_q_count)
    );

    tbd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_geom       (w_geom),
        .i_wv         (w_wv),
        .i_scale      (r_scale),
        .i_offset     (r_offset),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_value      (w_value),
        .o_row        (w_row),
        .o_col        (w_col),
        .o_last       (o_m_tlast),
        .o_eof        (o_m_tuser)
    );

    assign o_m_tdata = {4'b0, w_col, w_row, w_value};

endmodule

// File: bench/triangular_blur_downscaler_tb.sv
`timescale 1ns / 1ps

module triangular_blur_downscaler_tb;
    import tbd_pkg::*;

    typedef struct {
        logic signed [23:0] value;
        logic [9:0]         orow;
        logic [9:0]         ocol;
        logic               last;
        logic               eof;
    } blur_beat_t;

    class blur_scoreboard;
        logic [15:0]  ring [RING*MAX_WIDTH];
        int           row_pos;
        int           col_pos;
        int           kernel;
        int           factor;
        longint       gain;
        longint       bias;
        int           width;
        int           height;
        blur_beat_t   awaited [$];
        int           errors;

        function new();
            foreach (ring[n]) ring[n] = '0;
            row_pos = 0;
            col_pos = 0;
            kernel  = 3;
            factor  = 1;
            gain    = 268435456;
            bias    = 0;
            width   = 1024;
            height  = 1024;
            errors  = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [31:0] data);
            case (idx)
                CFG_KERNEL: kernel = int'(data[4:0]);
                CFG_DOWN:   factor = int'(data[4:0]);
                CFG_SCALE:  gain = longint'(data);
                CFG_OFFSET: bias = longint'($signed(data[23:0]));
                CFG_WIDTH:  width = int'(data[10:0]);
                CFG_HEIGHT: height = int'(data[10:0]);
                default: ;
            endcase
            if (idx == CFG_KERNEL || idx == CFG_DOWN || idx == CFG_WIDTH ||
                idx == CFG_HEIGHT) begin
                row_pos = 0;
                col_pos = 0;
            end
        endfunction

        function int clip(int v, int lo, int hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function int weight(int d, int r, bit even);
            int a;
            int b;
            int w;
            a = d < 0 ? -d : d;
            w = (a <= r) ? r + 1 - a : 0;
            if (even) begin
                b = (d + 1) < 0 ? -(d + 1) : d + 1;
                w += (b <= r) ? r + 1 - b : 0;
            end
            return w;
        endfunction

        function bit kept(int idx, int ds, int n, output int o);
            int off;
            off = ds / 2;
            o = 0;
            if (idx < off || (idx - off) % ds != 0) return 0;
            if ((idx - off) / ds >= n / ds) return 0;
            o = (idx - off) / ds;
            return 1;
        endfunction

        function longint weighted_sum(int i, int j, int r, bit even, int w, int h);
            longint s;
            int wv;
            int wh;
            int base;
            s = 0;
            for (int dr = -r - 1; dr <= r; dr++) begin
                wv = weight(dr, r, even);
                if (wv == 0) continue;
                base = (clip(i + dr, 0, h - 1) % RING) * MAX_WIDTH;
                for (int dc = -r - 1; dc <= r; dc++) begin
                    wh = weight(dc, r, even);
                    if (wh == 0) continue;
                    s += longint'(wv * wh) *
                         longint'($signed(ring[base + clip(j + dc, 0, w - 1)]));
                end
            end
            return s;
        endfunction

        function void note_input(logic drain, logic [15:0] pix);
            int k;
            int r;
            int ds;
            int w;
            int h;
            int i;
            int jlo;
            int jhi;
            int orow;
            int ocol;
            int first;
            bit even;
            longint q;
            blur_beat_t b;
            k  = clip(kernel, 1, MAX_KERNEL);
            even = (k % 2) == 0;
            r  = (k - 1) / 2;
            ds = factor == 0 ? 1 : factor;
            w  = clip(width, 1, MAX_WIDTH);
            h  = clip(height, 1, 1024);
            if (col_pos >= w || row_pos >= h + r) begin
                row_pos = 0;
                col_pos = 0;
            end
            if (row_pos < h) begin
                if (drain) return;
                ring[(row_pos % RING) * MAX_WIDTH + col_pos] = pix;
            end
            first = awaited.size();
            i = row_pos - r;
            if (i >= 0 && kept(i, ds, h, orow)) begin
                if (col_pos < w - 1) begin
                    jlo = col_pos - r;
                    jhi = col_pos - r;
                end else begin
                    jlo = w - 1 - r < 0 ? 0 : w - 1 - r;
                    jhi = w - 1;
                end
                for (int j = (jlo < 0 ? 0 : jlo); j <= jhi; j++) begin
                    if (!kept(j, ds, w, ocol)) continue;
                    q = weighted_sum(i, j, r, even, w, h) * gain;
                    q = ((q + 64'sd2147483648) >>> 32) + bias;
                    q = q < -8388608 ? -8388608 : (q > 8388607 ? 8388607 : q);
                    b.value = q[23:0];
                    b.orow  = orow[9:0];
                    b.ocol  = ocol[9:0];
                    b.last  = 0;
                    b.eof   = (orow == h / ds - 1) && (ocol == w / ds - 1);
                    awaited.push_back(b);
                end
            end
            if (awaited.size() > first) awaited[awaited.size() - 1].last = 1;
            col_pos++;
            if (col_pos >= w) begin
                col_pos = 0;
                row_pos++;
                if (row_pos >= h + r) row_pos = 0;
            end
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $time, what);
            errors++;
        endtask

        task check_result(logic [47:0] data, logic last, logic eof);
            blur_beat_t b;
            if (awaited.size() == 0) begin
                report($sformatf("unexpected beat %h", data));
                return;
            end
            b = awaited.pop_front();
            if (data[23:0] !== b.value || data[33:24] !== b.orow ||
                data[43:34] !== b.ocol || data[47:44] !== 4'd0 ||
                last !== b.last || eof !== b.eof)
                report($sformatf("got v=%h r=%0d c=%0d l=%b e=%b, want v=%h r=%0d c=%0d l=%b e=%b",
                                 data[23:0], data[33:24], data[43:34], last, eof,
                                 b.value, b.orow, b.ocol, b.last, b.eof));
        endtask
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_s_tvalid = 0;
    logic [15:0] i_s_tdata = '0;
    logic        i_s_tuser = 0;
    logic        i_m_tready = 0;
    logic        i_cfg_valid = 0;
    logic [2:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [47:0] o_m_tdata;
    logic        o_m_tlast;
    logic        o_m_tuser;
    logic        o_cfg_ready;

    blur_scoreboard blur_sb = new();
    bit             calm = 0;
    int             ready_hold = 0;
    longint         cycles = 0;

    triangular_blur_downscaler dut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 1500000) begin
            $display("[FAIL] regression broken");
            $finish;
        end
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) blur_sb.note_input(i_s_tuser, i_s_tdata);
            if (o_m_tvalid && i_m_tready) blur_sb.check_result(o_m_tdata, o_m_tlast, o_m_tuser);
            if (i_cfg_valid && o_cfg_ready)
                blur_sb.write_reg(t_cfg_idx'(i_cfg_index), i_cfg_data);
        end
    end

    always @(negedge i_clk) begin
        if (calm) begin
            i_m_tready <= 1;
        end else if (ready_hold > 0) begin
            ready_hold--;
            i_m_tready <= 0;
        end else if ($urandom_range(0, 15) == 0) begin
            ready_hold = $urandom_range(1, 19) - 1;
            i_m_tready <= 0;
        end else begin
            i_m_tready <= 1;
        end
    end

    task send_beat(logic drain, logic [15:0] pix);
        if (!calm && $urandom_range(0, 11) == 0) begin
            i_s_tvalid = 0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        i_s_tvalid = 1;
        i_s_tuser  = drain;
        i_s_tdata  = pix;
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
        i_s_tvalid = 0;
    endtask

    task settle();
        while (blur_sb.awaited.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task write_reg(t_cfg_idx idx, logic [31:0] data);
        i_cfg_valid = 1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 0;
    endtask

    function logic [15:0] pick_pixel();
        case ($urandom_range(0, 5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task run_frame(int k, int ds, logic [31:0] gain, logic [31:0] bias, int w, int h);
        int r;
        settle();
        write_reg(CFG_KERNEL, k);
        write_reg(CFG_DOWN, ds);
        write_reg(CFG_SCALE, gain);
        write_reg(CFG_OFFSET, bias);
        write_reg(CFG_WIDTH, w);
        write_reg(CFG_HEIGHT, h);
        r = (k - 1) / 2;
        for (int n = 0; n < w * h; n++) begin
            if ($urandom_range(0, 19) == 0) send_beat(1, 16'($urandom));
            send_beat(0, pick_pixel());
        end
        for (int n = 0; n < w * r; n++)
            send_beat($urandom_range(0, 3) != 0, 16'($urandom));
    endtask

    initial begin
        int k;
        int r;
        int w;
        int h;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        write_reg(CFG_KERNEL, 3);
        write_reg(CFG_WIDTH, 1024);
        write_reg(CFG_HEIGHT, 1024);
        send_beat(0, 16'h7FFF);
        send_beat(0, 16'h8000);
        send_beat(1, 16'h1234);
        send_beat(0, 16'h0000);
        send_beat(0, 16'hFFFF);
        send_beat(0, 16'h5555);
        send_beat(0, 16'hAAAA);

        run_frame(1, 1, 32'hFFFFFFFF, 32'h7FFFFF, 4, 1);
        run_frame(2, 2, 32'hFFFFFFFF, 32'h800000, 6, 3);
        run_frame(3, 1, 32'h10000000, 32'h000000, 4, 2);
        run_frame(8, 3, 32'h02000000, 32'h000010, 8, 4);

        k = $urandom_range(1, 4);
        r = (k - 1) / 2;
        w = $urandom_range(4, r * 2 + 4);
        h = $urandom_range(r + 1, r + 2);
        calm = 1;
        run_frame(k, $urandom_range(0, 4) == 0 ? $urandom_range(1, 16) : $urandom_range(1, 3),
                  $urandom, $urandom, w, h);

        settle();
        if (blur_sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
